// File: rtl/wep_passphrase_key_generator_unit_assert.svh
// Assertion macros for the WEP passphrase key generator.
`ifndef WEP_PASSPHRASE_KEY_GENERATOR_UNIT_ASSERT_SVH
`define WEP_PASSPHRASE_KEY_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define WPK_ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define WPK_ASSERT_SEQ(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WPK_ASSERT_IMPL(label, clk, rst_n, cond)
`define WPK_ASSERT_SEQ(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/wpk_pkg.sv
// Types and constants for the WEP passphrase key generator.
package wpk_pkg;

    localparam logic [31:0] LCG_MUL = 32'h0003_43fd;
    localparam logic [31:0] LCG_ADD = 32'h0026_9ec3;
    localparam int KEY_BYTES = 20;
    localparam int HASH_BYTES = 64;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_LCG,
        ST_FILL,
        ST_HASH,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] MD5_IV [4] = '{32'h67452301, 32'hefcdab89,
                                         32'h98badcfe, 32'h10325476};

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

endpackage

// File: rtl/wep_passphrase_key_generator_unit.sv
// Top level of the WEP passphrase key generator.
// Characters are taken one per cycle while busy is low. On an item with
// i_end_of_phrase set, busy rises and the 20 key bytes follow on o_key_valid;
// they cannot be held off. 40-bit mode: 20 LCG steps, a key byte from each.
// Strong mode: the phrase store (one synchronous RAM, one read a cycle) is
// swept into the message RAM, then two MD5 blocks (one read lead-in, then
// one round a cycle) run: the first reads one message word a cycle from it,
// the second uses padding words decoded from the round index. Each block is
// followed by a chaining add, then the key bytes are emitted.
// The LCG multiply is split into two 16-bit halves in successive cycles.
module wep_passphrase_key_generator_unit #(
    parameter int STRONG_KEY_BYTES = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_key_char,
    input  logic       i_end_of_phrase,
    output logic       o_key_valid,
    output logic [7:0] o_key_byte,
    output logic [4:0] o_byte_index,
    output logic       o_last_byte
);

    `include "wep_passphrase_key_generator_unit_assert.svh"

    wpk_pkg::t_state r_state, n_state;

    logic        r_strong;
    logic [31:0] r_seed;
    logic [6:0]  r_count;
    logic [1:0]  r_lane;

    logic [7:0]  phrase_mem [64];
    logic [7:0]  r_phrase_q;
    logic [31:0] msg_mem [16];
    logic [31:0] r_msg_q;

    logic [6:0]  r_step;      // general step counter
    logic [5:0]  r_src;       // replay pointer into phrase store
    logic        r_fill_v;    // r_phrase_q holds byte for r_step-1
    logic [31:0] r_word;
    logic        r_blk;       // second MD5 block
    logic        r_half;      // LCG multiply phase
    logic [31:0] r_lo;
    logic [31:0] r_s;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_h [4];
    logic [4:0]  r_out_idx;

    logic take, add_ch;
    assign busy   = (r_state != wpk_pkg::ST_COLLECT);
    assign take   = start && !busy;
    assign add_ch = take && (i_key_char != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strong <= 1'b0;
        else if (i_cfg_we) r_strong <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (add_ch && !r_count[6]) phrase_mem[r_count[5:0]] <= i_key_char;
        r_phrase_q <= phrase_mem[r_src];
    end

    // message RAM: block 1 words from fill sweep, block 2 decoded as padding
    logic        msg_we;
    logic [3:0]  msg_wa;
    logic [31:0] msg_wd;
    logic [5:0]  rnd;
    logic [5:0]  rr;
    logic [31:0] msg_word;
    assign rnd = r_step[5:0];
    always_ff @(posedge i_clk) begin
        if (msg_we) msg_mem[msg_wa] <= msg_wd;
        r_msg_q <= msg_mem[wpk_pkg::md5_g(rnd)];
    end
    always_comb begin
        if (!r_blk) msg_word = r_msg_q;
        else if (wpk_pkg::md5_g(rr) == 4'd0) msg_word = 32'h80;
        else if (wpk_pkg::md5_g(rr) == 4'd14) msg_word = 32'(wpk_pkg::HASH_BYTES * 8);
        else msg_word = 32'd0;
    end

    // fill: r_step 0..64 issues reads, byte arrives in the next cycle
    logic [7:0] fill_byte;
    logic [5:0] fill_pos;
    assign fill_byte = (r_count == 7'd0) ? 8'd0 : r_phrase_q;
    assign fill_pos  = 6'(r_step - 7'd1);
    assign msg_we    = (r_state == wpk_pkg::ST_FILL) && r_fill_v && (fill_pos[1:0] == 2'd3);
    assign msg_wa    = fill_pos[5:2];
    assign msg_wd    = {fill_byte, r_word[31:8]};

    // MD5 round; message arrives in the cycle after its address, so round rr
    // trails r_step by one and r_step 0 is the read lead-in
    logic [31:0] f, t, rot, k;
    assign rr = 6'(r_step - 7'd1);
    always_comb begin
        case (rr[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_d & r_b) | (~r_d & r_c);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        k   = wpk_pkg::md5_k(rr);
        t   = r_a + f + k + msg_word;
        rot = (t << wpk_pkg::md5_rot(rr)) | (t >> (6'd32 - {1'b0, wpk_pkg::md5_rot(rr)}));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpk_pkg::ST_COLLECT:
                if (take && i_end_of_phrase)
                    n_state = r_strong ? wpk_pkg::ST_FILL : wpk_pkg::ST_LCG;
            wpk_pkg::ST_LCG:
                if (r_out_idx == 5'(wpk_pkg::KEY_BYTES - 1) && r_half)
                    n_state = wpk_pkg::ST_COLLECT;
            wpk_pkg::ST_FILL:
                if (r_step == 7'd64) n_state = wpk_pkg::ST_HASH;
            wpk_pkg::ST_HASH:
                if (r_step == 7'd64) n_state = wpk_pkg::ST_ADD;
            wpk_pkg::ST_ADD:
                n_state = r_blk ? wpk_pkg::ST_EMIT : wpk_pkg::ST_HASH;
            wpk_pkg::ST_EMIT:
                if (r_out_idx == 5'(wpk_pkg::KEY_BYTES - 1)) n_state = wpk_pkg::ST_COLLECT;
            default: n_state = wpk_pkg::ST_COLLECT;
        endcase
    end

    logic [31:0] lcg_next;
    assign lcg_next = r_lo + {r_s[31:16] * wpk_pkg::LCG_MUL[15:0], 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpk_pkg::ST_COLLECT;
            r_seed <= '0; r_count <= '0; r_lane <= '0;
            r_step <= '0; r_src <= '0; r_fill_v <= 1'b0; r_blk <= 1'b0;
            r_half <= 1'b0; r_out_idx <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                wpk_pkg::ST_COLLECT: begin
                    r_step <= '0; r_src <= '0; r_fill_v <= 1'b0; r_blk <= 1'b0;
                    r_half <= 1'b0; r_out_idx <= '0;
                    if (add_ch) begin
                        r_seed <= r_seed ^ (32'(i_key_char) << {r_lane, 3'b000});
                        r_lane <= r_lane + 2'd1;
                        if (!r_count[6]) r_count <= r_count + 7'd1;
                    end
                    if (take && i_end_of_phrase) begin
                        r_s <= add_ch ? r_seed ^ (32'(i_key_char) << {r_lane, 3'b000})
                                      : r_seed;
                        r_h <= wpk_pkg::MD5_IV;
                        r_a <= wpk_pkg::MD5_IV[0]; r_b <= wpk_pkg::MD5_IV[1];
                        r_c <= wpk_pkg::MD5_IV[2]; r_d <= wpk_pkg::MD5_IV[3];
                    end
                end
                wpk_pkg::ST_LCG: begin
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_lo <= r_s[15:0] * wpk_pkg::LCG_MUL + wpk_pkg::LCG_ADD;
                    end else begin
                        r_s <= lcg_next;
                        r_out_idx <= r_out_idx + 5'd1;
                    end
                end
                wpk_pkg::ST_FILL: begin
                    r_step <= (r_step == 7'd64) ? 7'd0 : r_step + 7'd1;
                    r_fill_v <= 1'b1;
                    r_src <= (7'(r_src) + 7'd1 >= r_count) ? 6'd0 : r_src + 6'd1;
                    if (r_fill_v) r_word <= {fill_byte, r_word[31:8]};
                end
                wpk_pkg::ST_HASH: begin
                    r_step <= (r_step == 7'd64) ? 7'd0 : r_step + 7'd1;
                    if (r_step != 7'd0) begin
                        r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + rot;
                    end
                end
                wpk_pkg::ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
                    r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
                    r_blk <= 1'b1;
                end
                wpk_pkg::ST_EMIT: r_out_idx <= r_out_idx + 5'd1;
                default: ;
            endcase
            if (n_state == wpk_pkg::ST_COLLECT && busy) begin
                r_seed <= '0; r_count <= '0; r_lane <= '0;
            end
        end
    end

    logic [31:0] h_sel;
    logic [1:0]  hw;
    assign hw = r_out_idx[3:2];
    always_comb begin
        case (hw)
            2'd0: h_sel = r_h[0];
            2'd1: h_sel = r_h[1];
            2'd2: h_sel = r_h[2];
            default: h_sel = r_h[3];
        endcase
        o_key_valid  = ((r_state == wpk_pkg::ST_LCG) && r_half) ||
                       (r_state == wpk_pkg::ST_EMIT);
        o_byte_index = r_out_idx;
        o_last_byte  = (r_out_idx == 5'(wpk_pkg::KEY_BYTES - 1));
        if (r_state == wpk_pkg::ST_LCG) o_key_byte = lcg_next[23:16];
        else if (32'(r_out_idx) < 32'(STRONG_KEY_BYTES) && !r_out_idx[4])
            o_key_byte = h_sel[{r_out_idx[1:0], 3'b000} +: 8];
        else o_key_byte = 8'd0;
    end

    `WPK_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, r_count <= 7'd64)
    `WPK_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, !o_key_valid || busy)
    `WPK_ASSERT_SEQ(a_last_idle, i_clk, i_rst_n, o_key_valid && o_last_byte, !busy)
    `WPK_ASSERT_SEQ(a_end_busy, i_clk, i_rst_n, take && i_end_of_phrase, busy)

endmodule

// File: dv/wep_passphrase_key_generator_unit_tb.sv
// Self-checking testbench for the WEP passphrase key generator unit.
`timescale 1ns / 1ps

module wep_passphrase_key_generator_unit_tb;

    typedef struct packed {
        logic [7:0] key_byte;
        logic [4:0] byte_index;
        logic       last_byte;
    } t_key_out;

    typedef struct {
        logic [7:0] ch;
        logic       eop;
        logic       chk;
        logic [7:0] first_byte;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_key_char = '0;
    logic       i_end_of_phrase = 1'b0;
    logic       o_key_valid;
    logic [7:0] o_key_byte;
    logic [4:0] o_byte_index;
    logic       o_last_byte;

    wep_passphrase_key_generator_unit i_dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic        strong_sel;
    logic [31:0] seed;
    int          n_chars;
    logic [1:0]  lane;
    logic [7:0]  phrase [wpk_pkg::HASH_BYTES];
    t_key_out    key_queue [$];
    int          n_bad = 0;
    int          sender_idle = 0;
    logic [7:0]  first_key = '0;

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic int shift_of(int r);
        int tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        return tab[((r / 16) * 4) + (r % 4)];
    endfunction

    function automatic void md5_compress(ref logic [31:0] h [4], input logic [31:0] m [16]);
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d); g = r;
            end else if (r < 32) begin
                f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d; g = (3 * r + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * r) % 16;
            end
            t = a + f + wpk_pkg::md5_k(6'(r)) + m[g];
            t = rotl(t, shift_of(r));
            a = d; d = c; c = b; b = b + t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    endfunction

    function automatic void add_key_char(logic [7:0] ch);
        seed ^= 32'(ch) << (8 * lane);
        lane++;
        if (n_chars < wpk_pkg::HASH_BYTES) begin
            phrase[n_chars] = ch;
            n_chars++;
        end
    endfunction

    function automatic void predict_key(logic [7:0] ch, logic eop);
        logic [7:0]  kb [wpk_pkg::KEY_BYTES];
        logic [7:0]  buff [wpk_pkg::HASH_BYTES];
        logic [31:0] m [16];
        logic [31:0] h [4];
        logic [31:0] s;
        int j;
        if (ch != 0) add_key_char(ch);
        if (!eop) return;
        if (strong_sel) begin
            j = 0;
            for (int i = 0; i < wpk_pkg::HASH_BYTES; i++) begin
                if (n_chars == 0) buff[i] = '0;
                else begin
                    if (j >= n_chars) j = 0;
                    buff[i] = phrase[j];
                    j++;
                end
            end
            h = wpk_pkg::MD5_IV;
            for (int i = 0; i < 16; i++)
                m[i] = {buff[4*i+3], buff[4*i+2], buff[4*i+1], buff[4*i]};
            md5_compress(h, m);
            for (int i = 0; i < 16; i++) m[i] = '0;
            m[0] = 32'h80;
            m[14] = 32'(wpk_pkg::HASH_BYTES * 8);
            md5_compress(h, m);
            for (int i = 0; i < wpk_pkg::KEY_BYTES; i++)
                kb[i] = (i < 13) ? h[i / 4][8 * (i % 4) +: 8] : 8'h00;
        end else begin
            s = seed;
            for (int i = 0; i < wpk_pkg::KEY_BYTES; i++) begin
                s = s * wpk_pkg::LCG_MUL + wpk_pkg::LCG_ADD;
                kb[i] = s[23:16];
            end
        end
        for (int i = 0; i < wpk_pkg::KEY_BYTES; i++)
            key_queue.push_back('{kb[i], 5'(i), i == wpk_pkg::KEY_BYTES - 1});
        seed = '0;
        n_chars = 0;
        lane = '0;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_key_out got, exp_k;
        if (i_rst_n && o_key_valid) begin
            got = '{o_key_byte, o_byte_index, o_last_byte};
            if (o_byte_index == 5'd0) first_key = o_key_byte;
            if (key_queue.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected key byte %h idx %0d", o_key_byte,
                                          o_byte_index);
            end else begin
                exp_k = key_queue.pop_front();
                if (got !== exp_k) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_k.key_byte, exp_k.byte_index, exp_k.last_byte,
                                 got.key_byte, got.byte_index, got.last_byte);
                end
            end
        end
    end

    task automatic write_mode(logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        strong_sel = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (key_queue.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one transaction; start held while busy
    task automatic send_char(logic [7:0] ch, logic eop);
        while ($urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_key_char <= ch;
        i_end_of_phrase <= eop;
        do @(posedge i_clk); while (busy);
        predict_key(ch, eop);
        if (eop) begin
            start <= 1'b0;
            drain();
        end
    endtask

    task automatic send_phrase(int len, logic flavour);
        for (int i = 0; i < len; i++)
            send_char(flavour ? 8'($urandom_range(1, 255)) : 8'($urandom), 1'b0);
        send_char(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom), 1'b1);
    endtask

    initial begin
        t_row rows [$];
        int sent;
        int idle_tab [4] = '{0, 84, 0, 13};
        seed = '0; n_chars = 0; lane = '0; strong_sel = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // LCG of seed 0: first byte is bits 23..16 of 0x269ec3
        rows = '{'{8'h00, 1'b1, 1'b1, 8'h26}, '{8'hff, 1'b0, 1'b0, 8'h0},
                 '{8'h00, 1'b0, 1'b0, 8'h0}, '{8'h01, 1'b0, 1'b0, 8'h0},
                 '{8'h80, 1'b1, 1'b0, 8'h0}, '{8'hff, 1'b1, 1'b0, 8'h0},
                 '{8'h55, 1'b0, 1'b0, 8'h0}, '{8'haa, 1'b0, 1'b0, 8'h0},
                 '{8'h7f, 1'b0, 1'b0, 8'h0}, '{8'hfe, 1'b0, 1'b0, 8'h0},
                 '{8'h00, 1'b1, 1'b0, 8'h0}};
        foreach (rows[i]) begin
            send_char(rows[i].ch, rows[i].eop);
            if (rows[i].chk && first_key !== rows[i].first_byte) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: row %0d first byte exp %h got %h", i,
                             rows[i].first_byte, first_key);
            end
        end
        write_mode(1'b1);
        foreach (rows[i]) send_char(rows[i].ch, rows[i].eop);
        send_phrase(70, 1'b1);   // long phrase past the hash buffer
        write_mode(1'b0);
        send_phrase(70, 1'b1);
        sent = 0;
        for (int p = 0; p < 4; p++) begin
            sender_idle = idle_tab[p];
            write_mode(p[0]);
            while (sent < 30 * (p + 1)) begin
                int len;
                len = ($urandom_range(19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 9);
                send_phrase(len, $urandom_range(4) != 0);
                sent += len + 1;
            end
        end
        drain();
        repeat (400) @(posedge i_clk);
        if (n_bad == 0 && key_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
